/* rtl/dopt_pkg.sv */
// Shared types and constants for the DRAM open page tracker.
`timescale 1ns / 1ps

package dopt_pkg;

    localparam int BANK_ENTRIES = 16;
    localparam int BLOCK_ADDR_W = 28;
    localparam int BYTE_ADDR_W = 32;
    localparam int OFFSET_W = 3;
    localparam int ROW_W = 14;
    localparam int COL_W = 11;
    localparam int BANK_W = 4;
    localparam int LAT_W = 10;
    localparam int TOTAL_W = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 3'd6;

    typedef enum logic [1:0] {
        OUTCOME_HIT = 2'd0,
        OUTCOME_COL_CHANGE = 2'd1,
        OUTCOME_ROW_MISS = 2'd2
    } t_outcome;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLOCK_OFFSET = 3'd0,
        CFG_MAPPING_MODE = 3'd1,
        CFG_HIT_CYCLES = 3'd2,
        CFG_COL_CHANGE_CYCLES = 3'd3,
        CFG_ROW_MISS_CYCLES = 3'd4
    } t_cfg_index;

    typedef enum logic {
        MAP_ROW_INTERLEAVE = 1'b0,
        MAP_BLOCK_INTERLEAVE = 1'b1
    } t_map_mode;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [BANK_W-1:0] bank;
        logic [COL_W-1:0] col;
    } t_addr_fields;

endpackage

/* rtl/dopt_in_if.sv */
// Input channel carrying one block address per word.
`timescale 1ns / 1ps

interface dopt_in_if;
    logic valid;
    logic ready;
    logic [dopt_pkg::BLOCK_ADDR_W-1:0] block_address;

    modport source (output valid, output block_address, input ready);
    modport sink (input valid, input block_address, output ready);
endinterface

/* rtl/dopt_out_if.sv */
// Output channel carrying one classified access per word.
`timescale 1ns / 1ps

interface dopt_out_if;
    logic valid;
    logic ready;
    logic [1:0] outcome;
    logic [dopt_pkg::BANK_W-1:0] bank_index;
    logic [dopt_pkg::LAT_W-1:0] added_cycles;
    logic [dopt_pkg::TOTAL_W-1:0] cycle_total;

    modport source (output valid, output outcome, output bank_index, output added_cycles,
                    output cycle_total, input ready);
    modport sink (input valid, input outcome, input bank_index, input added_cycles,
                  input cycle_total, output ready);
endinterface

/* rtl/dopt_addr_map.sv */
// Address rebuild and row, bank and column split under the two mappings.
`timescale 1ns / 1ps

module dopt_addr_map (
    input  logic [dopt_pkg::BLOCK_ADDR_W-1:0] i_block_address,
    input  logic [dopt_pkg::OFFSET_W-1:0]     i_offset_bits,
    input  dopt_pkg::t_map_mode               i_mode,
    output dopt_pkg::t_addr_fields            o_fields
);

    logic [dopt_pkg::BYTE_ADDR_W-1:0] w_addr;

    assign w_addr = {{(dopt_pkg::BYTE_ADDR_W - dopt_pkg::BLOCK_ADDR_W){1'b0}}, i_block_address}
                    << i_offset_bits;

    always_comb begin
        o_fields.row = w_addr[31:18];
        case (i_mode)
            dopt_pkg::MAP_ROW_INTERLEAVE: begin
                o_fields.bank = w_addr[17:14];
                o_fields.col = w_addr[13:3];
            end
            dopt_pkg::MAP_BLOCK_INTERLEAVE: begin
                o_fields.bank = {w_addr[8:6], w_addr[17]};
                o_fields.col = {w_addr[16:9], w_addr[5:3]};
            end
            default: begin
                o_fields.bank = w_addr[17:14];
                o_fields.col = w_addr[13:3];
            end
        endcase
    end

endmodule

/* rtl/dopt_bank_table.sv */
// Per-bank open row and column store with access classification and update.
`timescale 1ns / 1ps

module dopt_bank_table (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  dopt_pkg::t_addr_fields i_fields,
    output dopt_pkg::t_outcome     o_outcome
);

    logic [dopt_pkg::BANK_ENTRIES-1:0] r_row_valid;
    logic [dopt_pkg::ROW_W-1:0]        r_row [dopt_pkg::BANK_ENTRIES];
    logic [dopt_pkg::COL_W-1:0]        r_col [dopt_pkg::BANK_ENTRIES];

    always_comb begin
        if (!r_row_valid[i_fields.bank] || r_row[i_fields.bank] != i_fields.row) begin
            o_outcome = dopt_pkg::OUTCOME_ROW_MISS;
        end else if (r_col[i_fields.bank] != i_fields.col) begin
            o_outcome = dopt_pkg::OUTCOME_COL_CHANGE;
        end else begin
            o_outcome = dopt_pkg::OUTCOME_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_en && o_outcome == dopt_pkg::OUTCOME_ROW_MISS) begin
            r_row_valid[i_fields.bank] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (o_outcome == dopt_pkg::OUTCOME_ROW_MISS) begin
                r_row[i_fields.bank] <= i_fields.row;
            end
            if (o_outcome != dopt_pkg::OUTCOME_HIT) begin
                r_col[i_fields.bank] <= i_fields.col;
            end
        end
    end

    // An updated bank always holds an open row matching the access afterward.
    a_bank_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_row_valid[$past(i_fields.bank)]
                 && r_row[$past(i_fields.bank)] == $past(i_fields.row))
        else $error("bank entry not open after access");

    a_col_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en |=> r_col[$past(i_fields.bank)] == $past(i_fields.col))
        else $error("open column not recorded after access");

    a_hit_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && o_outcome != dopt_pkg::OUTCOME_ROW_MISS |-> r_row_valid[i_fields.bank])
        else $error("row hit reported on an empty bank");

endmodule

/* rtl/dram_open_page_tracker_top.sv */
// Top level of the DRAM open page tracker.
`timescale 1ns / 1ps

// The tracker takes one block address word per cycle and returns one word per access with
// the outcome (row and column hit, column change or row miss), the bank, the latency added
// and the saturating running cycle total. A word moves from the input to the output register
// when the output can take it; the bank lookup, compare and write-back and the total update
// all happen in that single step, so throughput is one word per cycle while the output side
// takes words. Reset closes all banks at once. The user must write configuration
// through the plain write port while no words are in flight; the block does not enforce it.
module dram_open_page_tracker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    dopt_in_if.sink                             i_in,
    dopt_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  logic [dopt_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [dopt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [dopt_pkg::OFFSET_W-1:0]     r_offset_bits;
    dopt_pkg::t_map_mode               r_mode;
    logic [dopt_pkg::LAT_W-1:0]        r_hit_cycles;
    logic [dopt_pkg::LAT_W-1:0]        r_col_change_cycles;
    logic [dopt_pkg::LAT_W-1:0]        r_row_miss_cycles;

    logic                              r_in_valid;
    logic [dopt_pkg::BLOCK_ADDR_W-1:0] r_block_address;

    logic                              r_out_valid;
    dopt_pkg::t_outcome                r_outcome;
    logic [dopt_pkg::BANK_W-1:0]       r_bank;
    logic [dopt_pkg::LAT_W-1:0]        r_added;
    logic [dopt_pkg::TOTAL_W-1:0]      r_total;

    logic                              w_advance;
    dopt_pkg::t_addr_fields            w_fields;
    dopt_pkg::t_outcome                w_outcome;
    logic [dopt_pkg::LAT_W-1:0]        w_added;
    logic [dopt_pkg::TOTAL_W:0]        w_sum;
    logic [dopt_pkg::TOTAL_W-1:0]      n_total;

    assign w_advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits <= dopt_pkg::OFFSET_RESET;
            r_mode <= dopt_pkg::MAP_ROW_INTERLEAVE;
            r_hit_cycles <= '0;
            r_col_change_cycles <= '0;
            r_row_miss_cycles <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dopt_pkg::CFG_BLOCK_OFFSET: begin
                    r_offset_bits <= i_cfg_data[dopt_pkg::OFFSET_W-1:0];
                end
                dopt_pkg::CFG_MAPPING_MODE: begin
                    r_mode <= dopt_pkg::t_map_mode'(i_cfg_data[0]);
                end
                dopt_pkg::CFG_HIT_CYCLES: begin
                    r_hit_cycles <= i_cfg_data[dopt_pkg::LAT_W-1:0];
                end
                dopt_pkg::CFG_COL_CHANGE_CYCLES: begin
                    r_col_change_cycles <= i_cfg_data[dopt_pkg::LAT_W-1:0];
                end
                dopt_pkg::CFG_ROW_MISS_CYCLES: begin
                    r_row_miss_cycles <= i_cfg_data[dopt_pkg::LAT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_block_address <= i_in.block_address;
        end
    end

    dopt_addr_map u_addr_map (
        .i_block_address (r_block_address),
        .i_offset_bits   (r_offset_bits),
        .i_mode          (r_mode),
        .o_fields        (w_fields)
    );

    dopt_bank_table u_bank_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_advance),
        .i_fields  (w_fields),
        .o_outcome (w_outcome)
    );

    always_comb begin
        case (w_outcome)
            dopt_pkg::OUTCOME_HIT:        w_added = r_hit_cycles;
            dopt_pkg::OUTCOME_COL_CHANGE: w_added = r_col_change_cycles;
            dopt_pkg::OUTCOME_ROW_MISS:   w_added = r_row_miss_cycles;
            default:                      w_added = r_row_miss_cycles;
        endcase
    end

    // A carry out of the total means the sum passed the maximum, so clamp it.
    assign w_sum = {1'b0, r_total} + (dopt_pkg::TOTAL_W + 1)'(w_added);
    assign n_total = w_sum[dopt_pkg::TOTAL_W] ? '1 : w_sum[dopt_pkg::TOTAL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total <= '0;
        end else begin
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_total <= n_total;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_outcome <= w_outcome;
            r_bank <= w_fields.bank;
            r_added <= w_added;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.outcome = r_outcome;
    assign o_out.bank_index = r_bank;
    assign o_out.added_cycles = r_added;
    assign o_out.cycle_total = r_total;

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_total >= $past(r_total))
        else $error("running total decreased");

    a_total_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> r_total == $past(r_total))
        else $error("running total changed without an access");

    a_no_lost_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid)
        else $error("pending output word dropped");

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the DRAM open page tracker with a predictor and random traffic.
`timescale 1ns / 1ps

import dopt_pkg::*;

typedef struct {
    t_outcome outcome;
    logic [BANK_W-1:0] bank;
    logic [LAT_W-1:0] added;
    logic [TOTAL_W-1:0] total;
} access_result_t;

class open_page_scoreboard;
    logic [OFFSET_W-1:0] offset_bits;
    t_map_mode mapping;
    logic [LAT_W-1:0] hit_lat;
    logic [LAT_W-1:0] col_lat;
    logic [LAT_W-1:0] miss_lat;
    bit row_open [BANK_ENTRIES];
    logic [ROW_W-1:0] open_row [BANK_ENTRIES];
    logic [COL_W-1:0] open_col [BANK_ENTRIES];
    logic [TOTAL_W-1:0] total;
    access_result_t expected_accesses [$];
    int unsigned errors;
    int unsigned checked;
    int unsigned outcome_count [3];

    function new();
        offset_bits = OFFSET_RESET;
        mapping = MAP_ROW_INTERLEAVE;
        hit_lat = '0;
        col_lat = '0;
        miss_lat = '0;
        total = '0;
        errors = 0;
        checked = 0;
        foreach (row_open[i]) row_open[i] = 1'b0;
        foreach (outcome_count[i]) outcome_count[i] = 0;
    endfunction

    function int unsigned pending();
        return expected_accesses.size();
    endfunction

    function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        case (t_cfg_index'(idx))
            CFG_BLOCK_OFFSET: offset_bits = value[OFFSET_W-1:0];
            CFG_MAPPING_MODE: mapping = t_map_mode'(value[0]);
            CFG_HIT_CYCLES: hit_lat = value[LAT_W-1:0];
            CFG_COL_CHANGE_CYCLES: col_lat = value[LAT_W-1:0];
            CFG_ROW_MISS_CYCLES: miss_lat = value[LAT_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_access(logic [BLOCK_ADDR_W-1:0] blk);
        logic [BYTE_ADDR_W-1:0] addr;
        logic [ROW_W-1:0] row;
        logic [BANK_W-1:0] bank;
        logic [COL_W-1:0] col;
        logic [TOTAL_W:0] sum;
        access_result_t r;
        addr = {{(BYTE_ADDR_W - BLOCK_ADDR_W){1'b0}}, blk} << offset_bits;
        row = addr[31:18];
        if (mapping == MAP_ROW_INTERLEAVE) begin
            bank = addr[17:14];
            col = addr[13:3];
        end else begin
            bank = {addr[8:6], addr[17]};
            col = {addr[16:9], addr[5:3]};
        end
        r.bank = bank;
        if (!row_open[bank] || open_row[bank] != row) begin
            r.outcome = OUTCOME_ROW_MISS;
            r.added = miss_lat;
            row_open[bank] = 1'b1;
            open_row[bank] = row;
            open_col[bank] = col;
        end else if (open_col[bank] != col) begin
            r.outcome = OUTCOME_COL_CHANGE;
            r.added = col_lat;
            open_col[bank] = col;
        end else begin
            r.outcome = OUTCOME_HIT;
            r.added = hit_lat;
        end
        sum = {1'b0, total} + r.added;
        total = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        r.total = total;
        expected_accesses.push_back(r);
    endfunction

    task report(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_word(logic [1:0] outcome, logic [BANK_W-1:0] bank,
                    logic [LAT_W-1:0] added, logic [TOTAL_W-1:0] cycle_total);
        access_result_t want;
        if (expected_accesses.size() == 0) begin
            report($sformatf("word with no access pending, bank %0d", bank));
            return;
        end
        want = expected_accesses.pop_front();
        checked++;
        outcome_count[want.outcome]++;
        if (outcome !== want.outcome)
            report($sformatf("word %0d outcome %0d, want %s", checked, outcome, want.outcome.name()));
        if (bank !== want.bank)
            report($sformatf("word %0d bank %0d, want %0d", checked, bank, want.bank));
        if (added !== want.added)
            report($sformatf("word %0d added %0d, want %0d", checked, added, want.added));
        if (cycle_total !== want.total)
            report($sformatf("word %0d total %0d, want %0d", checked, cycle_total, want.total));
    endtask

    task finish_check();
        if (expected_accesses.size() != 0)
            report($sformatf("%0d accesses never produced a word", expected_accesses.size()));
    endtask
endclass

module tb_top;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PHASES = 6;
    localparam int unsigned PHASE_WORDS = 210;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dopt_in_if in_if ();
    dopt_out_if out_if ();

    dram_open_page_tracker_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_if),
        .o_out(out_if),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    open_page_scoreboard tracker;
    bit no_idle;
    int unsigned cycle_count = 0;
    int unsigned settings_used = 1;
    logic [BLOCK_ADDR_W-1:0] recent_blocks [8];

    logic [BLOCK_ADDR_W-1:0] reset_probe [6] = '{
        28'h0000000, 28'h0000000, 28'h0000001, 28'hFFFFFFF, 28'hFFFFFFF, 28'h0000100
    };
    logic [BLOCK_ADDR_W-1:0] low_offset_probe [8] = '{
        28'h0000000, 28'h0000008, 28'h0000040, 28'h0020000,
        28'hFFFFFFF, 28'hFFFFFFF, 28'h5555555, 28'hAAAAAAA
    };
    logic [BLOCK_ADDR_W-1:0] high_offset_probe [6] = '{
        28'hFFFFFFF, 28'h8000000, 28'h0000000, 28'h0000001, 28'h0000002, 28'h7FFFFFF
    };

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (in_if.valid && in_if.ready)
            tracker.note_access(in_if.block_address);
        if (out_if.valid && out_if.ready)
            tracker.check_word(out_if.outcome, out_if.bank_index, out_if.added_cycles,
                               out_if.cycle_total);
    end

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 11);
    endfunction

    // Mostly reuses recent addresses so that hits and column changes occur often.
    function automatic logic [BLOCK_ADDR_W-1:0] pick_block_address();
        logic [BLOCK_ADDR_W-1:0] blk;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        blk = recent_blocks[$urandom_range(0, 7)];
        if (kind >= 30 && kind < 60)
            blk[$urandom_range(0, 11)] ^= 1'b1;
        else if (kind >= 60 && kind < 75)
            blk[$urandom_range(12, BLOCK_ADDR_W - 1)] ^= 1'b1;
        else if (kind >= 75)
            blk = BLOCK_ADDR_W'($urandom);
        recent_blocks[$urandom_range(0, 7)] = blk;
        return blk;
    endfunction

    task automatic send_word(input logic [BLOCK_ADDR_W-1:0] blk);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.block_address <= blk;
        do @(posedge i_clk); while (!in_if.ready);
        @(negedge i_clk);
    endtask

    task automatic drive_ready();
        int unsigned stall;
        forever begin
            stall = draw_gap();
            if (stall != 0) begin
                out_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!out_if.valid);
            @(negedge i_clk);
        end
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        tracker.set_register(idx, value);
        @(negedge i_clk);
    endtask

    // Upper data bits are random so that masking of the narrow registers is exercised.
    task automatic configure(input logic [OFFSET_W-1:0] offset, input t_map_mode mode,
                             input logic [LAT_W-1:0] hit, input logic [LAT_W-1:0] col,
                             input logic [LAT_W-1:0] miss);
        logic [CFG_DATA_W-1:0] value;
        value = CFG_DATA_W'($urandom);
        write_register(CFG_ROW_MISS_CYCLES + CFG_INDEX_W'($urandom_range(1, 3)), value);
        value[OFFSET_W-1:0] = offset;
        write_register(CFG_BLOCK_OFFSET, value);
        value = CFG_DATA_W'($urandom);
        value[0] = mode;
        write_register(CFG_MAPPING_MODE, value);
        write_register(CFG_HIT_CYCLES, hit);
        write_register(CFG_COL_CHANGE_CYCLES, col);
        write_register(CFG_ROW_MISS_CYCLES, miss);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        tracker = new();
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.block_address = '0;
        out_if.ready = 1'b0;
        no_idle = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        fork
            drive_ready();
        join_none

        foreach (reset_probe[i]) send_word(reset_probe[i]);
        settle();
        configure(3'd0, MAP_BLOCK_INTERLEAVE, '1, '1, '1);
        foreach (low_offset_probe[i]) send_word(low_offset_probe[i]);
        settle();
        configure(3'd7, MAP_ROW_INTERLEAVE, '0, 10'd512, '1);
        foreach (high_offset_probe[i]) send_word(high_offset_probe[i]);

        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: configure(3'd4, MAP_ROW_INTERLEAVE, '1, '1, '1);
                1: configure(3'd7, MAP_BLOCK_INTERLEAVE, '0, '0, '0);
                default: configure(OFFSET_W'($urandom), t_map_mode'($urandom_range(0, 1)),
                                   LAT_W'($urandom), LAT_W'($urandom), LAT_W'($urandom));
            endcase
            no_idle = (p == 2 || p == 5);
            foreach (recent_blocks[i]) recent_blocks[i] = BLOCK_ADDR_W'($urandom);
            repeat (PHASE_WORDS) send_word(pick_block_address());
        end

        settle();
        repeat (4) @(negedge i_clk);
        tracker.finish_check();
        $display("covered %0d accesses under %0d register settings", tracker.checked,
                 settings_used);
        $display("outcomes: %0d hits, %0d column changes, %0d row misses",
                 tracker.outcome_count[OUTCOME_HIT], tracker.outcome_count[OUTCOME_COL_CHANGE],
                 tracker.outcome_count[OUTCOME_ROW_MISS]);
        if (tracker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

/* filelist.f */
rtl/dopt_pkg.sv
rtl/dopt_in_if.sv
rtl/dopt_out_if.sv
rtl/dopt_addr_map.sv
rtl/dopt_bank_table.sv
rtl/dram_open_page_tracker_top.sv
tb/sv/tb_top.sv
